>>> src/tcst_pkg.sv
// Shared types and codes for the TCP connection state tracker.
// No dependencies; every other file imports this package.
package tcst_pkg;

    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_IP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT = 2'd1;

    localparam logic [31:0] SERVER_IP_RESET   = 32'd2130706433;
    localparam logic [15:0] SERVER_PORT_RESET = 16'd9999;

    // result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_OPENED  = 3'd1;
    localparam logic [2:0] EV_ACTIVE  = 3'd2;
    localparam logic [2:0] EV_CLOSED  = 3'd3;
    localparam logic [2:0] EV_STALE   = 3'd4;
    localparam logic [2:0] EV_DROPPED = 3'd5;

    localparam logic [4:0] WAIT_COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        ST_WAIT   = 2'd0,
        ST_ACTIVE = 2'd1,
        ST_CLOSED = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        flag_syn;
        logic        flag_fin;
        logic        flag_ack;
        logic        has_payload;
    } t_seg;

    typedef struct packed {
        logic [2:0] event_res;
        logic [4:0] waiting_count;
    } t_result;

    // lookup summary from the match unit
    typedef struct packed {
        logic    hit;
        logic    has_free;
        t_status status;
    } t_lookup;

endpackage

>>> src/tcst_match.sv
// Parallel lookup over the connection table: key match and lowest free entry.
// Depends on tcst_pkg.
module tcst_match
    import tcst_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic [ENTRIES-1:0] i_valid,
    input  logic [31:0]        i_ip     [ENTRIES],
    input  logic [15:0]        i_port   [ENTRIES],
    input  t_status            i_status [ENTRIES],
    input  logic [31:0]        i_key_ip,
    input  logic [15:0]        i_key_port,
    output logic [ENTRIES-1:0] o_match_oh,
    output logic [ENTRIES-1:0] o_free_oh,
    output t_lookup            o_lookup
);

    logic [1:0] status_or;

    always_comb begin
        status_or = 2'b00;
        for (int i = 0; i < ENTRIES; i++) begin
            o_match_oh[i] = i_valid[i] && (i_ip[i] == i_key_ip) && (i_port[i] == i_key_port);
            status_or     = status_or | (i_status[i] & {2{o_match_oh[i]}});
        end
    end

    // lowest clear bit of the valid vector
    assign o_free_oh = ~i_valid & (i_valid + ENTRIES'(1));

    always_comb begin
        o_lookup.hit      = |o_match_oh;
        o_lookup.has_free = ~&i_valid;
        unique case (status_or)
            2'd0:    o_lookup.status = ST_WAIT;
            2'd1:    o_lookup.status = ST_ACTIVE;
            2'd2:    o_lookup.status = ST_CLOSED;
            default: o_lookup.status = ST_CLOSED;
        endcase
    end

endmodule

>>> src/tcp_connection_state_tracker_top.sv
// Top level of the TCP connection state tracker: input register, table, result register.
// Depends on tcst_pkg and tcst_match.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------
//  segment   | start && !busy                 | i_seg (t_seg)
//  result    | o_result_valid, one cycle      | o_result (t_result)
//  config    | i_cfg_valid && o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One segment per cycle while busy is low. A taken segment sits in the input register
// while lookup and table update feed the result register. busy is high during reset
// and clears once reset is released; the table valid bits clear in that reset. The
// receiver cannot stall; nothing backs up.
module tcp_connection_state_tracker_top
    import tcst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_seg                 i_seg,
    output logic                 o_result_valid,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W    = (CNT_BITS > 5) ? CNT_BITS : 5;

    logic                     r_busy;
    logic                     r_in_vld;
    t_seg                     r_seg;
    logic                     r_res_vld;
    t_result                  r_res;
    logic [31:0]              r_host_ip;
    logic [15:0]              r_host_port;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [31:0]              r_ip     [TABLE_ENTRIES];
    logic [15:0]              r_port   [TABLE_ENTRIES];
    t_status                  r_status [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_wait;
    logic [CNT_W-1:0]         n_wait;

    logic                     accept;
    logic                     from_srv;
    logic                     to_srv;
    logic [31:0]              key_ip;
    logic [15:0]              key_port;
    logic [TABLE_ENTRIES-1:0] match_oh;
    logic [TABLE_ENTRIES-1:0] free_oh;
    t_lookup                  lookup;

    logic       set_status;
    t_status    new_status;
    logic       do_insert;
    logic       do_erase;
    logic       cnt_inc;
    logic       cnt_dec;
    logic [2:0] n_event;

    assign accept         = start && !r_busy;
    assign busy           = r_busy;
    assign o_cfg_ready    = !r_busy;
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    assign from_srv = (r_seg.source_ip == r_host_ip) && (r_seg.source_port == r_host_port);
    assign to_srv   = (r_seg.dest_ip == r_host_ip) && (r_seg.dest_port == r_host_port);
    assign key_ip   = from_srv ? r_seg.dest_ip : r_seg.source_ip;
    assign key_port = from_srv ? r_seg.dest_port : r_seg.source_port;

    tcst_match #(
        .ENTRIES(TABLE_ENTRIES)
    ) u_match (
        .i_valid    (r_valid),
        .i_ip       (r_ip),
        .i_port     (r_port),
        .i_status   (r_status),
        .i_key_ip   (key_ip),
        .i_key_port (key_port),
        .o_match_oh (match_oh),
        .o_free_oh  (free_oh),
        .o_lookup   (lookup)
    );

    always_comb begin
        set_status = 1'b0;
        new_status = ST_WAIT;
        do_insert  = 1'b0;
        do_erase   = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        n_event    = EV_NONE;
        priority if (!r_in_vld) begin
            n_event = EV_NONE;
        end else if (from_srv) begin
            // server data: waiting -> active, server FIN+ACK: active -> closed; a hit in any other status is stale
            if (r_seg.has_payload) begin
                if (lookup.hit) begin
                    if (lookup.status == ST_WAIT) begin
                        set_status = 1'b1;
                        new_status = ST_ACTIVE;
                        cnt_dec    = 1'b1;
                        n_event    = EV_ACTIVE;
                    end else begin
                        do_erase = 1'b1;
                        n_event  = EV_STALE;
                    end
                end
            end else if (r_seg.flag_fin && r_seg.flag_ack) begin
                if (lookup.hit) begin
                    if (lookup.status == ST_ACTIVE) begin
                        set_status = 1'b1;
                        new_status = ST_CLOSED;
                        n_event    = EV_CLOSED;
                    end else begin
                        do_erase = 1'b1;
                        cnt_dec  = (lookup.status == ST_WAIT);
                        n_event  = EV_STALE;
                    end
                end
            end
        end else if (to_srv && r_seg.flag_syn) begin
            if (lookup.hit) begin
                set_status = 1'b1;
                new_status = ST_WAIT;
                cnt_inc    = (lookup.status != ST_WAIT);
                n_event    = EV_OPENED;
            end else if (lookup.has_free) begin
                do_insert = 1'b1;
                cnt_inc   = 1'b1;
                n_event   = EV_OPENED;
            end else begin
                n_event = EV_DROPPED;
            end
        end
    end

    always_comb begin
        n_wait = r_wait;
        if (cnt_inc) begin
            n_wait = r_wait + CNT_W'(1);
        end else if (cnt_dec) begin
            n_wait = r_wait - CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b1;
            r_in_vld    <= 1'b0;
            r_res_vld   <= 1'b0;
            r_wait      <= '0;
            r_valid     <= '0;
            r_host_ip   <= SERVER_IP_RESET;
            r_host_port <= SERVER_PORT_RESET;
        end else begin
            r_busy    <= 1'b0;
            r_in_vld  <= accept;
            r_res_vld <= r_in_vld;
            r_wait    <= n_wait;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (do_insert && free_oh[i]) begin
                    r_valid[i] <= 1'b1;
                end else if (do_erase && match_oh[i]) begin
                    r_valid[i] <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_SERVER_IP:   r_host_ip   <= i_cfg_data;
                    REG_SERVER_PORT: r_host_port <= i_cfg_data[15:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg <= i_seg;
        end
        r_res.event_res     <= n_event;
        r_res.waiting_count <= (n_wait > CNT_W'(WAIT_COUNT_MAX)) ? WAIT_COUNT_MAX
                                                                : n_wait[4:0];
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (do_insert && free_oh[i]) begin
                r_ip[i]     <= r_seg.source_ip;
                r_port[i]   <= r_seg.source_port;
                r_status[i] <= ST_WAIT;
            end else if (set_status && match_oh[i]) begin
                r_status[i] <= new_status;
            end
        end
    end

endmodule

>>> dv/tcp_connection_state_tracker_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for tcp_connection_state_tracker_top: directed and random segments,
// server address changes, results checked against fixed expectations or an in-bench connection table.
// Depends on tcst_pkg and the tracker RTL.
module tcp_connection_state_tracker_top_test;
    import tcst_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int CLIENTS       = 24;
    localparam int PHASE_ITEMS   = 157;

    localparam logic [3:0] F_SYN  = 4'b1000;
    localparam logic [3:0] F_FIN  = 4'b0100;
    localparam logic [3:0] F_ACK  = 4'b0010;
    localparam logic [3:0] F_DATA = 4'b0001;

    localparam logic [31:0] S_IP  = SERVER_IP_RESET;
    localparam logic [15:0] S_PT  = SERVER_PORT_RESET;
    localparam logic [31:0] C1_IP = 32'h0A00_0001;
    localparam logic [15:0] C1_PT = 16'd1234;
    localparam logic [31:0] C2_IP = 32'hC0A8_0002;
    localparam logic [15:0] C2_PT = 16'd80;
    localparam logic [31:0] IP_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] PT_MAX = 16'hFFFF;

    // flags packed as {syn, fin, ack, data}, same order as t_seg
    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  flags;
        logic        typed;
        logic [2:0]  ev;
        logic [4:0]  cnt;
    } t_seg_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_seg                 i_seg;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // mirror of the connection table
    logic        tbl_valid  [TABLE_ENTRIES];
    logic [31:0] tbl_ip     [TABLE_ENTRIES];
    logic [15:0] tbl_port   [TABLE_ENTRIES];
    t_status     tbl_status [TABLE_ENTRIES];
    logic [31:0] host_ip;
    logic [15:0] host_port;

    logic [31:0] pool_ip   [CLIENTS];
    logic [15:0] pool_port [CLIENTS];
    t_result     pending_results [$];
    bit          failed = 1'b0;

    t_seg_row directed_rows [25] = '{
        '{32'd0, 32'd0, 16'd0, 16'd0, 4'b0000, 1'b1, EV_NONE, 5'd0},
        '{IP_MAX, IP_MAX, PT_MAX, PT_MAX, 4'b1111, 1'b1, EV_NONE, 5'd0},
        '{C1_IP, S_IP, C1_PT, S_PT, F_SYN, 1'b1, EV_OPENED, 5'd1},
        '{C1_IP, S_IP, C1_PT, S_PT, F_SYN, 1'b1, EV_OPENED, 5'd1},
        '{C1_IP, S_IP, C1_PT, S_PT, F_FIN | F_ACK, 1'b1, EV_NONE, 5'd1},
        '{S_IP, C1_IP, S_PT, C1_PT, F_FIN | F_ACK, 1'b1, EV_STALE, 5'd0},
        '{C1_IP, S_IP, C1_PT, S_PT, F_SYN, 1'b1, EV_OPENED, 5'd1},
        '{S_IP, C1_IP, S_PT, C1_PT, F_DATA, 1'b1, EV_ACTIVE, 5'd0},
        '{S_IP, C1_IP, S_PT, C1_PT, F_FIN, 1'b1, EV_NONE, 5'd0},
        '{S_IP, C1_IP, S_PT, C1_PT, F_ACK, 1'b1, EV_NONE, 5'd0},
        '{S_IP, C1_IP, S_PT, C1_PT, F_FIN | F_ACK, 1'b1, EV_CLOSED, 5'd0},
        '{S_IP, C1_IP, S_PT, C1_PT, F_DATA, 1'b1, EV_STALE, 5'd0},
        '{C1_IP, S_IP, C1_PT, S_PT, F_SYN | F_ACK, 1'b1, EV_OPENED, 5'd1},
        '{S_IP, C1_IP, S_PT, C1_PT, F_DATA | F_FIN | F_ACK, 1'b1, EV_ACTIVE, 5'd0},
        '{S_IP, C1_IP, S_PT, C1_PT, F_DATA, 1'b1, EV_STALE, 5'd0},
        '{S_IP, C2_IP, S_PT, C2_PT, F_DATA, 1'b1, EV_NONE, 5'd0},
        '{S_IP, S_IP, S_PT, S_PT, F_SYN | F_DATA, 1'b1, EV_NONE, 5'd0},
        '{IP_MAX, S_IP, PT_MAX, S_PT, F_SYN, 1'b1, EV_OPENED, 5'd1},
        '{32'd0, S_IP, 16'd0, S_PT, F_SYN, 1'b1, EV_OPENED, 5'd2},
        '{C2_IP, S_IP, C2_PT, S_PT, F_SYN | F_FIN, 1'b0, EV_NONE, 5'd0},
        '{S_IP, 32'd0, S_PT, 16'd0, F_DATA, 1'b0, EV_NONE, 5'd0},
        '{S_IP, IP_MAX, S_PT, PT_MAX, F_FIN | F_ACK, 1'b0, EV_NONE, 5'd0},
        '{S_IP, 32'd0, S_PT, 16'd0, F_FIN | F_ACK, 1'b0, EV_NONE, 5'd0},
        '{32'd0, S_IP, 16'd0, S_PT, F_SYN, 1'b0, EV_NONE, 5'd0},
        '{C1_IP, S_IP, C1_PT, S_PT ^ 16'd1, F_SYN, 1'b0, EV_NONE, 5'd0}
    };

    tcp_connection_state_tracker_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_seg         (i_seg),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int find_client(input logic [31:0] ip, input logic [15:0] port);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port)
                return i;
        end
        return -1;
    endfunction

    // expected status moves on; any other status means the entry is stale
    function automatic logic [2:0] move_entry(input logic [31:0] ip, input logic [15:0] port,
                                              input t_status from_st, input t_status to_st,
                                              input logic [2:0] ev);
        int k;
        k = find_client(ip, port);
        if (k < 0)
            return EV_NONE;
        if (tbl_status[k] == from_st) begin
            tbl_status[k] = to_st;
            return ev;
        end
        tbl_valid[k]  = 1'b0;
        tbl_ip[k]     = '0;
        tbl_port[k]   = '0;
        tbl_status[k] = ST_WAIT;
        return EV_STALE;
    endfunction

    function automatic t_result track_segment(input t_seg s);
        t_result r;
        int      k;
        int      waiting;
        r.event_res = EV_NONE;
        if (s.source_ip == host_ip && s.source_port == host_port) begin
            if (s.has_payload)
                r.event_res = move_entry(s.dest_ip, s.dest_port, ST_WAIT, ST_ACTIVE, EV_ACTIVE);
            else if (s.flag_fin && s.flag_ack)
                r.event_res = move_entry(s.dest_ip, s.dest_port, ST_ACTIVE, ST_CLOSED, EV_CLOSED);
        end else if (s.dest_ip == host_ip && s.dest_port == host_port && s.flag_syn) begin
            k = find_client(s.source_ip, s.source_port);
            if (k < 0) begin
                // lowest free slot wins
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i])
                        k = i;
                end
                if (k >= 0) begin
                    tbl_valid[k] = 1'b1;
                    tbl_ip[k]    = s.source_ip;
                    tbl_port[k]  = s.source_port;
                end
            end
            if (k >= 0) begin
                tbl_status[k] = ST_WAIT;
                r.event_res   = EV_OPENED;
            end else begin
                r.event_res = EV_DROPPED;
            end
        end
        waiting = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_status[i] == ST_WAIT)
                waiting++;
        end
        r.waiting_count = (waiting > WAIT_COUNT_MAX) ? WAIT_COUNT_MAX : waiting[4:0];
        return r;
    endfunction

    // mostly well-formed client/server traffic over a small client pool, some noise
    function automatic t_seg rand_segment();
        t_seg s;
        int   c;
        int   kind;
        s.source_ip   = $urandom;
        s.dest_ip     = $urandom;
        s.source_port = 16'($urandom_range(0, 65535));
        s.dest_port   = 16'($urandom_range(0, 65535));
        {s.flag_syn, s.flag_fin, s.flag_ack, s.has_payload} = 4'($urandom_range(0, 15));
        c    = $urandom_range(0, CLIENTS - 1);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            s.source_ip   = pool_ip[c];
            s.source_port = pool_port[c];
            s.dest_ip     = host_ip;
            s.dest_port   = host_port;
            s.flag_syn    = ($urandom_range(0, 9) < 6);
        end else if (kind < 85) begin
            s.source_ip   = host_ip;
            s.source_port = host_port;
            s.dest_ip     = pool_ip[c];
            s.dest_port   = pool_port[c];
            if ($urandom_range(0, 1) == 0) begin
                s.has_payload = 1'b0;
                s.flag_fin    = ($urandom_range(0, 3) != 0);
            end
        end else if (kind < 88) begin
            s.source_ip   = host_ip;
            s.source_port = host_port;
            s.dest_ip     = host_ip;
            s.dest_port   = host_port;
        end else if (kind < 94) begin
            // right address, wrong port
            s.source_ip = host_ip;
            s.dest_ip   = host_ip;
            s.dest_port = pool_port[c];
        end
        return s;
    endfunction

    task automatic send_segment(input t_seg s, input logic typed, input t_result want);
        t_result predicted;
        start <= 1'b1;
        i_seg <= s;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = track_segment(s);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic idle_after_item(inout bit burst);
        int gap;
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int n);
        bit burst;
        burst = 1'b0;
        repeat (n) begin
            send_segment(rand_segment(), 1'b0, '0);
            if ($urandom_range(0, 39) == 0)
                drain_results();
            else
                idle_after_item(burst);
        end
    endtask

    task automatic set_server(input logic [31:0] ip, input logic [15:0] port);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_SERVER_IP;
        i_cfg_data  <= ip;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= REG_SERVER_PORT;
        i_cfg_data  <= {16'd0, port};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        host_ip   = ip;
        host_port = port;
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending: event_res %0d waiting_count %0d",
                       o_result.event_res, o_result.waiting_count);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_result.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res, o_result.event_res);
                    failed = 1'b1;
                end
                if (o_result.waiting_count !== want.waiting_count) begin
                    $error("waiting_count: expected %0d, got %0d",
                           want.waiting_count, o_result.waiting_count);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        bit       burst;
        t_seg_row row;
        start       = 1'b0;
        i_seg       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SERVER_IP;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        burst       = 1'b0;
        host_ip     = SERVER_IP_RESET;
        host_port   = SERVER_PORT_RESET;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_ip[i]     = '0;
            tbl_port[i]   = '0;
            tbl_status[i] = ST_WAIT;
        end
        pool_ip[0]   = 32'd0;
        pool_port[0] = 16'd0;
        pool_ip[1]   = IP_MAX;
        pool_port[1] = PT_MAX;
        for (int i = 2; i < CLIENTS; i++) begin
            pool_ip[i]   = $urandom;
            pool_port[i] = 16'($urandom_range(0, 65535));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            send_segment(t_seg'({row.sip, row.dip, row.sport, row.dport, row.flags}),
                         row.typed, '{row.ev, row.cnt});
            idle_after_item(burst);
        end
        run_random(PHASE_ITEMS);
        drain_results();

        set_server(32'd0, 16'd0);
        run_random(PHASE_ITEMS);
        drain_results();

        set_server(IP_MAX, PT_MAX);
        run_random(PHASE_ITEMS);
        drain_results();

        set_server($urandom, 16'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS);
        drain_results();

        if (!failed)
            $display("tcp_connection_state_tracker_top_test: clean");
        else
            $display("tcp_connection_state_tracker_top_test: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tcp_connection_state_tracker_top_test: errors");
        $finish;
    end

endmodule
